// File: sv/kmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmv_pkg: shared types and constants
// Widths, cell-row geometry and control bundles of the KMV sketch.
// ----------------------------------------------------------------------------
package kmv_pkg;

  localparam int MAX_BUCKETS = 256;
  localparam int HASH_W      = 64;
  localparam int CAP_W       = 9;
  localparam int KEPT_W      = 9;
  localparam int CNT_W       = $clog2(MAX_BUCKETS + 2);
  localparam int NCELL       = MAX_BUCKETS + 1;
  localparam int GRP_SZ      = 16;
  localparam int NGRP        = (NCELL + GRP_SZ - 1) / GRP_SZ;
  localparam int NPAD        = NGRP * GRP_SZ;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam hash_t ALL_ONES = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_UPD,
    ST_RD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic flag_en;
    logic rd_en;
  } grp_ctrl_t;

  typedef struct packed {
    logic any_eq;
    logic any_ge;
  } grp_flags_t;

endpackage

// File: sv/kmv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmv_if: stream channels of the KMV sketch
// Hash input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kmv_in_if import kmv_pkg::*; ();
  logic  valid;
  logic  ready;
  hash_t hash_word;

  modport source (output valid, output hash_word, input ready);
  modport sink   (input valid, input hash_word, output ready);
endinterface

interface kmv_out_if import kmv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEPT_W-1:0] kept_count;
  hash_t             threshold;
  logic              inserted;

  modport source (output valid, output kept_count, output threshold, output inserted,
                  input ready);
  modport sink   (input valid, input kept_count, input threshold, input inserted,
                  output ready);
endinterface

// File: sv/k_minimum_values_sketch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_minimum_values_sketch_top: k-minimum-values distinct-count sketch
// Keeps the smallest distinct 64-bit hashes in a sorted row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one hash per beat (valid/ready).
//   out_if : one result beat per hash: kept count, threshold, inserted flag.
//   cfg_we / cfg_wdata : capacity write, taken at any edge with cfg_we high outside reset;
//            write only while no hash is in flight.
// Sequence:
//   From acceptance to its result in the output register a hash passes
//   compare in every cell, group reduction of match flags, shift of the
//   cell row, group read of the new largest entry and final update.
//   One hash is in flight at a time and the next beat is taken in the idle
//   cycle after the result loads.
// Reset:
//   rst_n low empties the sketch, sets the threshold to all ones and the
//   capacity to 256, and holds in_if.ready low. No clearing pass is needed.
// Stall:
//   The result waits in the output register; the next hash is still
//   accepted and its result waits in the final stage until the slot frees.
// ----------------------------------------------------------------------------
module k_minimum_values_sketch_top import kmv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  kmv_in_if.sink           in_if,
  kmv_out_if.source        out_if
);

  state_t           state_r;
  state_t           state_nxt;
  logic [CAP_W-1:0] cap_r;
  cnt_t             count_r;
  cnt_t             count_nxt;
  hash_t            limit_r;
  hash_t            hash_r;
  logic             below_r;
  logic             set_lim_r;
  logic             ins_out_r;

  logic              out_valid_r;
  logic [KEPT_W-1:0] out_kept_r;
  hash_t             out_thr_r;
  logic              out_ins_r;

  cnt_t       cap_eff;
  logic       dup;
  logic       any_ge;
  logic       ins;
  cnt_t       cnt_after;
  logic       evict;
  logic       set_lim;
  hash_t      rd_or;
  hash_t      thr;
  logic       out_load;
  cell_ctrl_t cell_ctrl;
  grp_ctrl_t  grp_ctrl;

  hash_t             cell_val [NCELL];
  logic [NCELL-1:0]  cell_lt;
  logic [NCELL-1:0]  cell_eq;
  logic [NCELL-1:0]  entry_valid;
  logic [NPAD-1:0]   eq_v;
  logic [NPAD-1:0]   ge_v;
  logic [NPAD-1:0]   sel_v;
  hash_t             val_pad [NPAD];
  grp_flags_t        grp_flags [NGRP];
  hash_t             grp_rd [NGRP];

  // capacity clamp
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_r) > MAX_BUCKETS) begin
      cap_eff = CNT_W'(MAX_BUCKETS);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // cell row
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    assign entry_valid[i] = count_r > CNT_W'(i);
    if (i == 0) begin : g_head
      kmv_cell u_cell (
        .clk         (clk),
        .ctrl        (cell_ctrl),
        .hash_in     (hash_r),
        .entry_valid (entry_valid[i]),
        .prev_val    (hash_r),
        .prev_lt     (1'b1),
        .val         (cell_val[i]),
        .lt          (cell_lt[i]),
        .eq          (cell_eq[i])
      );
    end else begin : g_body
      kmv_cell u_cell (
        .clk         (clk),
        .ctrl        (cell_ctrl),
        .hash_in     (hash_r),
        .entry_valid (entry_valid[i]),
        .prev_val    (cell_val[i-1]),
        .prev_lt     (cell_lt[i-1]),
        .val         (cell_val[i]),
        .lt          (cell_lt[i]),
        .eq          (cell_eq[i])
      );
    end
  end

  // pad to whole groups
  for (genvar p = 0; p < NPAD; p++) begin : g_pad
    if (p < NCELL) begin : g_live
      assign eq_v[p]    = cell_eq[p];
      assign ge_v[p]    = entry_valid[p] && !cell_lt[p];
      assign sel_v[p]   = count_r == CNT_W'(p + 1);
      assign val_pad[p] = cell_val[p];
    end else begin : g_fill
      assign eq_v[p]    = 1'b0;
      assign ge_v[p]    = 1'b0;
      assign sel_v[p]   = 1'b0;
      assign val_pad[p] = '0;
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    hash_t gvals [GRP_SZ];
    for (genvar k = 0; k < GRP_SZ; k++) begin : g_tap
      assign gvals[k] = val_pad[g*GRP_SZ + k];
    end
    kmv_group u_group (
      .clk    (clk),
      .ctrl   (grp_ctrl),
      .eq     (eq_v[g*GRP_SZ +: GRP_SZ]),
      .ge     (ge_v[g*GRP_SZ +: GRP_SZ]),
      .sel    (sel_v[g*GRP_SZ +: GRP_SZ]),
      .vals   (gvals),
      .flags  (grp_flags[g]),
      .rd_val (grp_rd[g])
    );
  end

  // final reduction over groups
  always_comb begin
    dup    = 1'b0;
    any_ge = 1'b0;
    rd_or  = '0;
    for (int g = 0; g < NGRP; g++) begin
      dup    = dup | grp_flags[g].any_eq;
      any_ge = any_ge | grp_flags[g].any_ge;
      rd_or  = rd_or | grp_rd[g];
    end
  end

  assign ins       = below_r && !dup;
  assign cnt_after = count_r + CNT_W'(ins);
  assign evict     = below_r && (cnt_after > cap_eff);
  assign set_lim   = below_r && (cnt_after >= cap_eff);
  assign thr       = set_lim_r ? rd_or : limit_r;

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    cell_ctrl.cmp_en   = 1'b0;
    cell_ctrl.shift_en = 1'b0;
    grp_ctrl.flag_en   = 1'b0;
    grp_ctrl.rd_en     = 1'b0;
    out_load           = 1'b0;
    count_nxt          = count_r;
    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cell_ctrl.cmp_en = 1'b1;
        state_nxt        = ST_GRP;
      end
      ST_GRP: begin
        grp_ctrl.flag_en = 1'b1;
        state_nxt        = ST_UPD;
      end
      ST_UPD: begin
        cell_ctrl.shift_en = ins;
        count_nxt          = cnt_after - CNT_W'(evict);
        state_nxt          = ST_RD;
      end
      ST_RD: begin
        grp_ctrl.rd_en = 1'b1;
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      limit_r     <= ALL_ONES;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        limit_r     <= thr;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      hash_r <= in_if.hash_word;
    end
    if (state_r == ST_CMP) begin
      below_r <= hash_r < limit_r;
    end
    if (state_r == ST_UPD) begin
      set_lim_r <= set_lim;
      ins_out_r <= ins && !(evict && !any_ge);
    end
    if (out_load) begin
      out_kept_r <= KEPT_W'(count_r);
      out_thr_r  <= thr;
      out_ins_r  <= ins_out_r;
    end
  end

  assign in_if.ready       = rst_n && (state_r == ST_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.kept_count = out_kept_r;
  assign out_if.threshold  = out_thr_r;
  assign out_if.inserted   = out_ins_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= MAX_BUCKETS)
    else $error("held count above bucket limit");

  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> state_r == ST_CMP)
    else $error("accepted beat did not start compare");

  a_limit_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> limit_r <= $past(limit_r))
    else $error("threshold increased");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ins_out_r) |-> count_r != '0)
    else $error("insertion reported with empty sketch");

endmodule

// File: sv/kmv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmv_cell: one entry of the sorted hash row
// Compares its entry to the incoming hash and takes the hash or its left
// neighbor's entry when an insertion opens a slot at or below it.
// ----------------------------------------------------------------------------
module kmv_cell import kmv_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  hash_t      hash_in,
  input  logic       entry_valid,
  input  hash_t      prev_val,
  input  logic       prev_lt,
  output hash_t      val,
  output logic       lt,
  output logic       eq
);

  hash_t val_r;
  logic  lt_r;
  logic  eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r <= entry_valid && (val_r < hash_in);
      eq_r <= entry_valid && (val_r == hash_in);
    end
    if (ctrl.shift_en && !lt_r) begin
      val_r <= prev_lt ? hash_in : prev_val;
    end
  end

  assign val = val_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

// File: sv/kmv_group.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmv_group: registered reduction over one group of cells
// Collects match and order flags and reads out the selected entry.
// ----------------------------------------------------------------------------
module kmv_group import kmv_pkg::*; (
  input  logic              clk,
  input  grp_ctrl_t         ctrl,
  input  logic [GRP_SZ-1:0] eq,
  input  logic [GRP_SZ-1:0] ge,
  input  logic [GRP_SZ-1:0] sel,
  input  hash_t             vals [GRP_SZ],
  output grp_flags_t        flags,
  output hash_t             rd_val
);

  grp_flags_t flags_r;
  grp_flags_t flags_nxt;
  hash_t      rd_val_r;
  hash_t      rd_val_nxt;

  always_comb begin
    flags_nxt.any_eq = |eq;
    flags_nxt.any_ge = |ge;
    rd_val_nxt = '0;
    for (int k = 0; k < GRP_SZ; k++) begin
      if (sel[k]) begin
        rd_val_nxt = rd_val_nxt | vals[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.flag_en) begin
      flags_r <= flags_nxt;
    end
    if (ctrl.rd_en) begin
      rd_val_r <= rd_val_nxt;
    end
  end

  assign flags  = flags_r;
  assign rd_val = rd_val_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the k-minimum-values sketch
// Streams 64-bit hashes into the sketch under random gaps and output stalls,
// steps through capacity settings ending with zero and one, and checks
// every result beat against an in-bench copy of the sorted hash list.
// ----------------------------------------------------------------------------
module tb_top;
  import kmv_pkg::*;

  localparam int          NUM_DIRECTED = 17;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PRINT_LIMIT  = 100;

  typedef struct packed {
    logic [KEPT_W-1:0] kept_count;
    hash_t             threshold;
    logic              inserted;
  } sketch_result_t;

  typedef enum logic {ROW_HASH, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    hash_t          value;
    logic           typed;
    sketch_result_t want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_HASH, ALL_ONES,               1'b1, '{9'd0, ALL_ONES, 1'b0}},
    '{ROW_HASH, 64'd0,                  1'b1, '{9'd1, ALL_ONES, 1'b1}},
    '{ROW_HASH, 64'd0,                  1'b1, '{9'd1, ALL_ONES, 1'b0}},
    '{ROW_HASH, 64'hFFFF_FFFF_FFFF_FFFD, 1'b1, '{9'd2, ALL_ONES, 1'b1}},
    '{ROW_HASH, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, '{9'd3, ALL_ONES, 1'b1}},
    '{ROW_HASH, 64'h5555_5555_5555_5555, 1'b1, '{9'd4, ALL_ONES, 1'b1}},
    '{ROW_HASH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{9'd5, ALL_ONES, 1'b1}},
    '{ROW_CAP,  64'd3,                  1'b0, '0},
    '{ROW_HASH, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
    '{ROW_HASH, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0, '0},
    '{ROW_HASH, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
    '{ROW_HASH, 64'h5555_5555_5555_5555, 1'b0, '0},
    '{ROW_HASH, 64'hFFFF_FFFF_FFFF_FFEF, 1'b0, '0},
    '{ROW_HASH, 64'd0,                  1'b0, '0},
    '{ROW_CAP,  64'd511,                1'b0, '0},
    '{ROW_HASH, 64'd1,                  1'b0, '0},
    '{ROW_HASH, 64'hAAAA_AAAA_AAAA_AAA9, 1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  kmv_in_if  hash_ch ();
  kmv_out_if result_ch ();

  k_minimum_values_sketch_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (hash_ch),
    .out_if    (result_ch)
  );

  hash_t            kept_hashes [0:MAX_BUCKETS];
  int               kept_n;
  hash_t            cur_threshold;
  logic [CAP_W-1:0] cur_capacity;
  sketch_result_t   reports_due [$];
  bit               steady;
  int unsigned      mismatches;
  int unsigned      cycle_count;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic sketch_result_t absorb_hash(input hash_t h);
    int             cap;
    int             pos;
    bit             added;
    sketch_result_t r;
    if (cur_capacity == '0) cap = 1;
    else if (cur_capacity > MAX_BUCKETS) cap = MAX_BUCKETS;
    else cap = int'(cur_capacity);
    pos = 0;
    added = 1'b0;
    if (h < cur_threshold) begin
      while (pos < kept_n && kept_hashes[pos] < h) pos++;
      if (!(pos < kept_n && kept_hashes[pos] == h) && kept_n <= MAX_BUCKETS) begin
        for (int i = kept_n; i > pos; i--) kept_hashes[i] = kept_hashes[i-1];
        kept_hashes[pos] = h;
        kept_n++;
        added = 1'b1;
      end
      if (kept_n == cap) begin
        cur_threshold = kept_hashes[kept_n-1];
      end else if (kept_n > cap) begin
        if (added && pos == kept_n - 1) added = 1'b0;
        kept_n--;
        cur_threshold = kept_hashes[kept_n-1];
      end
    end
    r.kept_count = KEPT_W'(kept_n);
    r.threshold  = cur_threshold;
    r.inserted   = added;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Bias toward hashes that pass the threshold, duplicates and threshold edges.
  function automatic hash_t pick_hash();
    int unsigned roll;
    hash_t       r;
    r = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 45 && cur_threshold != '0) return r % cur_threshold;
    if (roll < 65 && kept_n != 0) return kept_hashes[$urandom_range(0, kept_n - 1)];
    if (roll < 75) begin
      case ($urandom_range(0, 2))
        0: return cur_threshold;
        1: return cur_threshold - 1;
        default: return cur_threshold + 1;
      endcase
    end
    if (roll < 80) return ALL_ONES;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t mismatch on %0s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Enter and leave on a falling edge.
  task automatic send_hash(input hash_t h, input logic typed, input sketch_result_t want);
    int unsigned    gap;
    sketch_result_t r;
    gap = idle_len();
    if (gap != 0) begin
      hash_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hash_ch.valid     <= 1'b1;
    hash_ch.hash_word <= h;
    do @(posedge clk); while (hash_ch.ready !== 1'b1);
    r = absorb_hash(h);
    if (typed) r = want;
    reports_due = {reports_due, r};
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    hash_ch.valid <= 1'b0;
    drain_results();
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we       <= 1'b0;
    cur_capacity  = value;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 199) == 0) begin
        hash_ch.valid <= 1'b0;
        @(negedge clk);
        drain_results();
      end
      send_hash(pick_hash(), 1'b0, '0);
    end
  endtask

  initial begin : result_sink
    int unsigned n;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      n = idle_len();
      if (n == 0) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    sketch_result_t want;
    if (rst_n && result_ch.valid === 1'b1 && result_ch.ready) begin
      if (reports_due.size() == 0) begin
        report_mismatch("unexpected beat", result_ch.threshold, '0);
      end else begin
        want = reports_due.pop_front();
        if (result_ch.kept_count !== want.kept_count)
          report_mismatch("kept_count", 64'(result_ch.kept_count), 64'(want.kept_count));
        if (result_ch.threshold !== want.threshold)
          report_mismatch("threshold", result_ch.threshold, want.threshold);
        if (result_ch.inserted !== want.inserted)
          report_mismatch("inserted", 64'(result_ch.inserted), 64'(want.inserted));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("k_minimum_values_sketch_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    hash_ch.valid     = 1'b0;
    hash_ch.hash_word = '0;
    steady            = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    kept_n            = 0;
    cur_threshold     = ALL_ONES;
    cur_capacity      = CAP_RESET;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_CAP)
        write_capacity(DIRECTED[i].value[CAP_W-1:0]);
      else
        send_hash(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
    end

    write_capacity(CAP_W'(256));
    steady = 1'b1;
    run_random(120);
    steady = 1'b0;
    run_random(380);
    write_capacity(CAP_W'(300));
    run_random(150);
    write_capacity(CAP_W'($urandom_range(100, 255)));
    run_random(250);
    write_capacity(CAP_W'($urandom_range(16, 64)));
    run_random(230);
    write_capacity(CAP_W'(511));
    steady = 1'b1;
    run_random(60);
    steady = 1'b0;
    run_random(60);
    write_capacity(CAP_W'($urandom_range(2, 8)));
    run_random(150);
    // Hold the smallest capacities for last: they pin the threshold near zero.
    write_capacity(CAP_W'(0));
    run_random(25);
    write_capacity(CAP_W'(1));
    run_random(25);

    hash_ch.valid <= 1'b0;
    @(negedge clk);
    drain_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("k_minimum_values_sketch_top regression: pass");
    else
      $display("k_minimum_values_sketch_top regression: fail");
    $finish;
  end

endmodule

// File: sim.f
sv/kmv_pkg.sv
sv/kmv_if.sv
sv/kmv_cell.sv
sv/kmv_group.sv
sv/k_minimum_values_sketch_top.sv
tb/tb_top.sv
